@@ rtl/tsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt-shift focus band blend: shared types and constants
// Register indexes, register reset values, pipeline depth and the
// structures that carry settings and pixel samples between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfb_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Stages that produce the blend weight, then the two blend stages.
   localparam int ALPHA_STAGES = 8;
   localparam int BLEND_STAGES = 2;
   localparam int NUM_STAGES   = ALPHA_STAGES + BLEND_STAGES;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EFFECT_ON     = 3'd0,
      CSR_FOCUS_ROW     = 3'd1,
      CSR_BAND_HALF     = 3'd2,
      CSR_FEATHER_RECIP = 3'd3,
      CSR_SLOPE         = 3'd4,
      CSR_CENTER_COL    = 3'd5
   } csr_index_type;

   localparam logic [16:0] ONE_Q16        = 17'd65536;
   localparam logic [15:0] FOCUS_ROW_RST  = 16'd32768;
   localparam logic [15:0] CENTER_COL_RST = 16'd32768;

   typedef struct packed {
      logic               effect_on;
      logic [15:0]        focus_row_q4;
      logic [15:0]        band_half_width_q4;
      logic [16:0]        feather_recip_q16;
      logic signed [17:0] slope_q12;
      logic [15:0]        center_col_q4;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        orig_l;
      logic signed [15:0] orig_a;
      logic signed [15:0] orig_b;
      logic [15:0]        blur_l;
      logic signed [15:0] blur_a;
      logic signed [15:0] blur_b;
   } pix_type;

endpackage

`default_nettype wire

@@ rtl/tsfb_alpha.sv @@
// ----------------------------------------------------------------------------
// Tilt-shift blend weight pipeline
// Eight register stages from pixel position to smoothstep weight in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfb_alpha #(
   parameter int MAX_WIDTH  = tsfb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = tsfb_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                                clock,
   input  wire logic [tsfb_pkg::ALPHA_STAGES-1:0]   stage_en,
   input  wire tsfb_pkg::cfg_type                   cfg,
   input  wire logic [11:0]                         col,
   input  wire logic [11:0]                         row,
   output logic [16:0]                              alpha
);

   localparam int LIM_W = 16;
   localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(MAX_WIDTH - 1);
   localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(MAX_HEIGHT - 1);

   // Stage 0: clamp coordinates, column offset from the center in Q.4.
   logic [11:0]        col_sat;
   logic [11:0]        row_sat;
   logic signed [16:0] dx_in, dx_ff;
   logic [15:0]        row0_in, row0_ff;

   always_comb begin
      col_sat = ({4'b0000, col} > COL_LIM) ? COL_LIM[11:0] : col;
      row_sat = ({4'b0000, row} > ROW_LIM) ? ROW_LIM[11:0] : row;
      dx_in   = $signed({1'b0, col_sat, 4'b0000}) - $signed({1'b0, cfg.center_col_q4});
      row0_in = {row_sat, 4'b0000};
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dx_ff   <= dx_in;
         row0_ff <= row0_in;
      end
   end

   // Stage 1: tilt product.
   logic signed [34:0] tilt_in, tilt_ff;
   logic [15:0]        row1_ff;

   assign tilt_in = dx_ff * cfg.slope_q12;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         tilt_ff <= tilt_in;
         row1_ff <= row0_ff;
      end
   end

   // Stage 2: band center, distance beyond the half width.
   logic signed [35:0] tilt_rnd;
   logic signed [35:0] tilt_shr;
   logic signed [24:0] centre;
   logic signed [24:0] row_off;
   logic signed [24:0] dist_mag;
   logic signed [24:0] over;
   logic [23:0]        dpos_in, dpos_ff;

   always_comb begin
      tilt_rnd = 36'(tilt_ff) + 36'sd2048;
      tilt_shr = tilt_rnd >>> 12;
      centre   = tilt_shr[24:0] + $signed({9'b0, cfg.focus_row_q4});
      row_off  = $signed({9'b0, row1_ff}) - centre;
      dist_mag = row_off[24] ? -row_off : row_off;
      over     = dist_mag - $signed({9'b0, cfg.band_half_width_q4});
      dpos_in  = over[24] ? 24'd0 : over[23:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         dpos_ff <= dpos_in;
      end
   end

   // Stage 3: distance times feather reciprocal (capped at one).
   logic [16:0] recip_c;
   logic [40:0] tprod_in, tprod_ff;

   always_comb begin
      recip_c  = cfg.feather_recip_q16[16] ? tsfb_pkg::ONE_Q16 : cfg.feather_recip_q16;
      tprod_in = 41'(dpos_ff) * 41'(recip_c);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         tprod_ff <= tprod_in;
      end
   end

   // Stage 4: t = floor(product / 16), clamped to one.
   logic [36:0] t_raw;
   logic [16:0] t4_in, t4_ff;

   always_comb begin
      t_raw = tprod_ff[40:4];
      t4_in = (t_raw > 37'(tsfb_pkg::ONE_Q16)) ? tsfb_pkg::ONE_Q16 : t_raw[16:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         t4_ff <= t4_in;
      end
   end

   // Stage 5: t squared.
   logic [33:0] tsq_in, tsq_ff;
   logic [16:0] t5_ff;

   assign tsq_in = 34'(t4_ff) * 34'(t4_ff);

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         tsq_ff <= tsq_in;
         t5_ff  <= t4_ff;
      end
   end

   // Stage 6: round t^2, multiply by (3 - 2t).
   logic [33:0] tsq_rnd;
   logic [16:0] t2;
   logic [17:0] cubic_k;
   logic [34:0] sprod_in, sprod_ff;

   always_comb begin
      tsq_rnd  = tsq_ff + 34'd32768;
      t2       = tsq_rnd[32:16];
      cubic_k  = 18'd196608 - {t5_ff, 1'b0};
      sprod_in = 35'(t2) * 35'(cubic_k);
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         sprod_ff <= sprod_in;
      end
   end

   // Stage 7: round the smoothstep, clamp to one, apply the enable.
   logic [35:0] sprod_rnd;
   logic [19:0] s_raw;
   logic [16:0] s7_in, s7_ff;

   always_comb begin
      sprod_rnd = 36'(sprod_ff) + 36'd32768;
      s_raw     = sprod_rnd[35:16];
      if (!cfg.effect_on) begin
         s7_in = 17'd0;
      end else if (s_raw > 20'(tsfb_pkg::ONE_Q16)) begin
         s7_in = tsfb_pkg::ONE_Q16;
      end else begin
         s7_in = s_raw[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_ff <= s7_in;
      end
   end

   assign alpha = s7_ff;

endmodule

`default_nettype wire

@@ rtl/tsfb_blend.sv @@
// ----------------------------------------------------------------------------
// Tilt-shift channel blend
// Two stages: weighted products per channel, then rounded sum and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfb_blend (
   input  wire logic                                clock,
   input  wire logic [tsfb_pkg::BLEND_STAGES-1:0]   stage_en,
   input  wire logic [16:0]                         alpha,
   input  wire tsfb_pkg::pix_type                   pix,
   output logic [15:0]                              out_l,
   output logic signed [15:0]                       out_a,
   output logic signed [15:0]                       out_b
);

   logic signed [16:0] orig_v [3];
   logic signed [16:0] blur_v [3];
   logic signed [17:0] w_orig;
   logic signed [17:0] w_blur;
   logic signed [34:0] po_in [3];
   logic signed [34:0] pb_in [3];
   logic signed [34:0] po_ff [3];
   logic signed [34:0] pb_ff [3];

   always_comb begin
      orig_v[0] = $signed({1'b0, pix.orig_l});
      orig_v[1] = 17'(pix.orig_a);
      orig_v[2] = 17'(pix.orig_b);
      blur_v[0] = $signed({1'b0, pix.blur_l});
      blur_v[1] = 17'(pix.blur_a);
      blur_v[2] = 17'(pix.blur_b);
      w_orig    = $signed({1'b0, tsfb_pkg::ONE_Q16 - alpha});
      w_blur    = $signed({1'b0, alpha});
      for (int c = 0; c < 3; c++) begin
         po_in[c] = orig_v[c] * w_orig;
         pb_in[c] = blur_v[c] * w_blur;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         po_ff <= po_in;
         pb_ff <= pb_in;
      end
   end

   logic signed [35:0] sum   [3];
   logic signed [35:0] shr   [3];
   logic [15:0]        l_in, l_ff;
   logic signed [15:0] a_in, a_ff;
   logic signed [15:0] b_in, b_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = 36'(po_ff[c]) + 36'(pb_ff[c]) + 36'sd32768;
         shr[c] = sum[c] >>> 16;
      end
      if (shr[0] < 36'sd0) begin
         l_in = 16'd0;
      end else if (shr[0] > 36'sd65535) begin
         l_in = 16'hFFFF;
      end else begin
         l_in = shr[0][15:0];
      end
      if (shr[1] < -36'sd32768) begin
         a_in = -16'sd32768;
      end else if (shr[1] > 36'sd32767) begin
         a_in = 16'sd32767;
      end else begin
         a_in = shr[1][15:0];
      end
      if (shr[2] < -36'sd32768) begin
         b_in = -16'sd32768;
      end else if (shr[2] > 36'sd32767) begin
         b_in = 16'sd32767;
      end else begin
         b_in = shr[2][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         l_ff <= l_in;
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign out_l = l_ff;
   assign out_a = a_ff;
   assign out_b = b_ff;

endmodule

`default_nettype wire

@@ rtl/tilt_shift_focus_band_blend.sv @@
// Throughput: one item per cycle while rsp_stall is low; the ten-stage pipeline,
// set by the four chained multiplies of the weight path and the blend products,
// fills bubbles under a stall and holds every item in place.
// Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// Tilt-shift focus band blend
// Computes a smoothstep weight from the distance to a tilted focus band and
// blends each Lab channel of the original pixel toward its blurred version.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_shift_focus_band_blend #(
   parameter int MAX_WIDTH  = tsfb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = tsfb_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Configuration writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tsfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tsfb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Input pixels
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [11:0]                        req_col,
   input  wire logic [11:0]                        req_row,
   input  wire logic [15:0]                        req_orig_l,
   input  wire logic signed [15:0]                 req_orig_a,
   input  wire logic signed [15:0]                 req_orig_b,
   input  wire logic [15:0]                        req_blur_l,
   input  wire logic signed [15:0]                 req_blur_a,
   input  wire logic signed [15:0]                 req_blur_b,
   // Results
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [15:0]                             rsp_out_l,
   output logic signed [15:0]                      rsp_out_a,
   output logic signed [15:0]                      rsp_out_b
);

   localparam int NS = tsfb_pkg::NUM_STAGES;
   localparam int NA = tsfb_pkg::ALPHA_STAGES;

   // Settings
   tsfb_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.effect_on          <= 1'b0;
         cfg_ff.focus_row_q4       <= tsfb_pkg::FOCUS_ROW_RST;
         cfg_ff.band_half_width_q4 <= 16'd0;
         cfg_ff.feather_recip_q16  <= tsfb_pkg::ONE_Q16;
         cfg_ff.slope_q12          <= 18'sd0;
         cfg_ff.center_col_q4      <= tsfb_pkg::CENTER_COL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (tsfb_pkg::csr_index_type'(csr_index))
            tsfb_pkg::CSR_EFFECT_ON:     cfg_ff.effect_on          <= csr_wdata[0];
            tsfb_pkg::CSR_FOCUS_ROW:     cfg_ff.focus_row_q4       <= csr_wdata[15:0];
            tsfb_pkg::CSR_BAND_HALF:     cfg_ff.band_half_width_q4 <= csr_wdata[15:0];
            tsfb_pkg::CSR_FEATHER_RECIP: cfg_ff.feather_recip_q16  <= csr_wdata[16:0];
            tsfb_pkg::CSR_SLOPE:         cfg_ff.slope_q12          <= $signed(csr_wdata);
            tsfb_pkg::CSR_CENTER_COL:    cfg_ff.center_col_q4      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow: a stage loads when it is empty or its successor loads.
   logic [NS-1:0] valid_ff;
   logic [NS:0]   rdy;

   always_comb begin
      rdy[NS] = !rsp_stall;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = valid_ff[NS-1];

   // Pixel samples ride alongside the weight pipeline.
   tsfb_pkg::pix_type pix_in;
   tsfb_pkg::pix_type pix_ff [NA];

   always_comb begin
      pix_in.orig_l = req_orig_l;
      pix_in.orig_a = req_orig_a;
      pix_in.orig_b = req_orig_b;
      pix_in.blur_l = req_blur_l;
      pix_in.blur_a = req_blur_a;
      pix_in.blur_b = req_blur_b;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NA; k++) begin
         if (rdy[k]) begin
            pix_ff[k] <= (k == 0) ? pix_in : pix_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   logic [16:0] alpha;

   tsfb_alpha #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_alpha (
      .clock    (clock),
      .stage_en (rdy[NA-1:0]),
      .cfg      (cfg_ff),
      .col      (req_col),
      .row      (req_row),
      .alpha    (alpha)
   );

   tsfb_blend u_blend (
      .clock    (clock),
      .stage_en (rdy[NS-1:NA]),
      .alpha    (alpha),
      .pix      (pix_ff[NA-1]),
      .out_l    (rsp_out_l),
      .out_a    (rsp_out_a),
      .out_b    (rsp_out_b)
   );

endmodule

`default_nettype wire
